@@ design/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define VIHQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("vihq: assertion failed");

// Clocked assertion that also holds across reset
`define VIHQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("vihq: assertion failed");

`endif

@@ design/vihq_pkg.sv @@
// Shared constants and types of the voted input hold qualifier
package vihq_pkg;

  // Sample window and lane split
  localparam int SAMPLE_COUNT = 8;
  localparam int FIELD_W      = 8;
  localparam int LANE_W       = 4;
  localparam int LANES        = (SAMPLE_COUNT + LANE_W - 1) / LANE_W;
  localparam int WIN_W        = LANES * LANE_W;
  localparam int LANE_CNT_W   = $clog2(LANE_W + 1);
  localparam int CNT_W        = $clog2(SAMPLE_COUNT + 1);
  localparam int VOTES_W      = 4;
  localparam int CMP_W        = (CNT_W > VOTES_W) ? CNT_W : VOTES_W;

  // Timer and configuration port
  localparam int HOLD_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [HOLD_W-1:0] ELAPSED_MAX = {HOLD_W{1'b1}};
  localparam logic [VOTES_W-1:0] MIN_VOTES_RST = VOTES_W'(5);
  localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST = HOLD_W'(10);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERT    = 2'd0,
    REG_BLOCK     = 2'd1,
    REG_MIN_VOTES = 2'd2,
    REG_HOLD      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                invert_input;
    logic                block_qualify;
    logic [VOTES_W-1:0]  min_votes;
    logic [HOLD_W-1:0]   hold_ticks;
  } vihq_cfg_t;

  typedef struct packed {
    logic real_level;
    logic qualified_level;
    logic change_event;
    logic ack_pending;
  } vihq_result_t;

endpackage

@@ design/vihq_if.sv @@
// Valid/ready channel interfaces for input and result words
interface vihq_in_if;
  import vihq_pkg::*;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [FIELD_W-1:0] sample_bits;
  modport source (output valid, mode, sample_bits, input ready);
  modport sink   (input valid, mode, sample_bits, output ready);
endinterface

interface vihq_out_if;
  logic valid;
  logic ready;
  logic real_level;
  logic qualified_level;
  logic change_event;
  logic ack_pending;
  modport source (output valid, real_level, qualified_level, change_event, ack_pending,
                  input ready);
  modport sink   (input valid, real_level, qualified_level, change_event, ack_pending,
                  output ready);
endinterface

@@ design/vihq_lane.sv @@
// One vote lane: counts active samples in its slice of the window
module vihq_lane (
  input  logic [vihq_pkg::LANE_W-1:0]     samples,
  input  logic [vihq_pkg::LANE_W-1:0]     in_range,
  output logic [vihq_pkg::LANE_CNT_W-1:0] active_cnt
);
  import vihq_pkg::*;

  // Count low samples that fall inside the window
  always_comb begin
    active_cnt = '0;
    for (int i = 0; i < LANE_W; i++) begin
      active_cnt = active_cnt + LANE_CNT_W'(in_range[i] & ~samples[i]);
    end
  end
endmodule

@@ design/vihq_core.sv @@
// Merge of lane counts, vote decision and hold qualification state
module vihq_core (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  vihq_pkg::vihq_cfg_t                              cfg,
  input  logic                                             fire,
  input  logic                                             mode,
  input  logic [vihq_pkg::LANES-1:0][vihq_pkg::LANE_CNT_W-1:0] lane_cnt,
  output vihq_pkg::vihq_result_t                           result
);
  import vihq_pkg::*;

  logic              real_r, real_nxt;
  logic              qual_r, qual_nxt;
  logic              pend_r, pend_nxt;
  logic              counting_r, counting_nxt;
  logic [HOLD_W-1:0] elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0]  active;
  logic [CNT_W-1:0]  inactive;
  logic              active_hit;
  logic              inactive_hit;
  logic              chg;

  // Merge the lane counts
  always_comb begin
    active = '0;
    for (int l = 0; l < LANES; l++) begin
      active = active + CNT_W'(lane_cnt[l]);
    end
  end

  assign inactive     = CNT_W'(SAMPLE_COUNT) - active;
  assign active_hit   = CMP_W'(active) >= CMP_W'(cfg.min_votes);
  assign inactive_hit = CMP_W'(inactive) >= CMP_W'(cfg.min_votes);

  // Work out the next state for the word at the input
  always_comb begin
    real_nxt     = real_r;
    qual_nxt     = qual_r;
    pend_nxt     = pend_r;
    counting_nxt = counting_r;
    elapsed_nxt  = elapsed_r;
    chg          = 1'b0;
    if (mode) begin
      pend_nxt = 1'b0;
    end else begin
      if (active_hit) begin
        real_nxt = ~cfg.invert_input;
      end else if (inactive_hit) begin
        real_nxt = cfg.invert_input;
      end
      if (counting_r && elapsed_r != ELAPSED_MAX) begin
        elapsed_nxt = elapsed_r + 1'b1;
      end
      if (!cfg.block_qualify) begin
        if (!qual_r && !pend_r) begin
          if (real_nxt && !counting_r) begin
            // start the hold timer
            counting_nxt = 1'b1;
            elapsed_nxt  = '0;
          end else if (!real_nxt) begin
            counting_nxt = 1'b0;
          end else if (elapsed_nxt > cfg.hold_ticks) begin
            qual_nxt = 1'b1;
            chg      = 1'b1;
          end
        end else if (!real_nxt && !pend_r) begin
          // release: restart the timer but leave it running as it was
          qual_nxt    = 1'b0;
          elapsed_nxt = '0;
          chg         = 1'b1;
        end
      end
      if (chg) begin
        pend_nxt = 1'b1;
      end
    end
  end

  // Advance the state on an accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_r     <= 1'b0;
      qual_r     <= 1'b0;
      pend_r     <= 1'b0;
      counting_r <= 1'b0;
      elapsed_r  <= '0;
    end else if (fire) begin
      real_r     <= real_nxt;
      qual_r     <= qual_nxt;
      pend_r     <= pend_nxt;
      counting_r <= counting_nxt;
      elapsed_r  <= elapsed_nxt;
    end
  end

  assign result = '{real_level:      real_nxt,
                    qualified_level: qual_nxt,
                    change_event:    chg,
                    ack_pending:     pend_nxt};
endmodule

@@ design/vihq_out_buf.sv @@
// Output register with a skid entry behind it
module vihq_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  vihq_pkg::vihq_result_t push_word,
  output logic                   can_push,
  vihq_out_if.source             out_ch
);
  import vihq_pkg::*;

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  vihq_result_t out_word_r, out_word_nxt;
  vihq_result_t skid_word_r, skid_word_nxt;
  logic         pop;

  assign pop      = out_valid_r && out_ch.ready;
  assign can_push = !skid_valid_r;

  // Refill the output from the skid entry first, then from the input; else park a pushed word in the skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_word_nxt   = out_word_r;
    skid_word_nxt  = skid_word_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_word_nxt   = skid_word_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_word_nxt  = push_word;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_word_nxt  = push_word;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Hold payload without reset
  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.real_level      = out_word_r.real_level;
  assign out_ch.qualified_level = out_word_r.qualified_level;
  assign out_ch.change_event    = out_word_r.change_event;
  assign out_ch.ack_pending     = out_word_r.ack_pending;
endmodule

@@ design/voted_input_hold_qualifier.sv @@
// A result word is registered into the output register, or into the skid entry while that register waits.
// Throughput: one word per cycle while the skid entry is empty; vote lanes, merge and next state are combinational.
// A register plus skid entry at the output keeps input open while one result waits.
// Input stalls only once both output entries hold undelivered words.
// Reset (synchronous, active low) clears control state and loads register defaults; result payload is not reset.
module voted_input_hold_qualifier (
  input  logic                            clk,
  input  logic                            rst_n,
  vihq_in_if.sink                         in_ch,
  vihq_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [vihq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vihq_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vihq_pkg::*;

  vihq_cfg_t                         cfg_r, cfg_nxt;
  logic [WIN_W-1:0]                  window;
  logic [WIN_W-1:0]                  in_range;
  logic [LANES-1:0][LANE_CNT_W-1:0]  lane_cnt;
  vihq_result_t                      result;
  logic                              can_push;
  logic                              in_fire;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INVERT:    cfg_nxt.invert_input  = cfg_wdata[0];
        REG_BLOCK:     cfg_nxt.block_qualify = cfg_wdata[0];
        REG_MIN_VOTES: cfg_nxt.min_votes     = cfg_wdata[VOTES_W-1:0];
        REG_HOLD:      cfg_nxt.hold_ticks    = cfg_wdata[HOLD_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{invert_input:  1'b0,
                 block_qualify: 1'b0,
                 min_votes:     MIN_VOTES_RST,
                 hold_ticks:    HOLD_TICKS_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Spread the window over the lanes; positions past the field read active
  for (genvar i = 0; i < WIN_W; i++) begin : g_win
    if (i < FIELD_W) begin : g_field
      assign window[i] = in_ch.sample_bits[i];
    end else begin : g_pad
      assign window[i] = 1'b0;
    end
    assign in_range[i] = (i < SAMPLE_COUNT);
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    vihq_lane u_lane (
      .samples    (window[l*LANE_W +: LANE_W]),
      .in_range   (in_range[l*LANE_W +: LANE_W]),
      .active_cnt (lane_cnt[l])
    );
  end

  assign in_ch.ready = can_push;
  assign in_fire     = in_ch.valid && can_push;

  vihq_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fire     (in_fire),
    .mode     (in_ch.mode),
    .lane_cnt (lane_cnt),
    .result   (result)
  );

  vihq_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_word (result),
    .can_push  (can_push),
    .out_ch    (out_ch)
  );
endmodule

@@ design/vihq_checker.sv @@
// Port-level checks of the voted input hold qualifier and their bind
`include "assert_macros.svh"

module vihq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_mode,
  input logic out_valid,
  input logic out_ready,
  input logic out_change_event,
  input logic out_ack_pending
);

  // Stalled result word stays offered
  `VIHQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)

  // Input is refused only while a result word is waiting
  `VIHQ_ASSERT(a_ready_only_when_full, clk, rst_n, !in_ready |-> out_valid)

  // An acknowledge word into an empty or draining output gives a clear result next cycle
  `VIHQ_ASSERT(a_ack_result, clk, rst_n,
    in_valid && in_ready && in_mode && (!out_valid || out_ready) |=>
    out_valid && !out_change_event && !out_ack_pending)

  // No result word right after reset
  `VIHQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind voted_input_hold_qualifier vihq_checker u_vihq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_mode          (in_ch.mode),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_change_event (out_ch.change_event),
  .out_ack_pending  (out_ch.ack_pending)
);
